// ----- sv/wctnp_pkg.sv -----
`default_nettype none

package wctnp_pkg;

   typedef logic [7:0] weight_type;
   typedef logic [7:0] out_byte_type;
   typedef logic [7:0] csr_data_type;
   typedef logic [1:0] csr_index_type;

   typedef enum logic {
      FUNC_LOAD  = 1'b0,
      FUNC_DRAIN = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_PARTIAL  = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   // register map
   localparam csr_index_type CSR_LANE_GROUPS = 2'd0;
   localparam csr_index_type CSR_CHAN_BLOCK  = 2'd1;
   localparam csr_index_type CSR_NIBBLE_MODE = 2'd2;

   // taps per input channel (3x3 kernel)
   localparam int unsigned TAPS_PER_CHAN = 9;
   // tap count fits 255 * 9
   localparam int unsigned TAP_W         = 12;
   localparam int unsigned NIBBLE_W      = 4;
   localparam logic [NIBBLE_W-1:0] NIBBLE_MASK = 4'hF;

endpackage

`default_nettype wire

// ----- sv/wctnp_if.sv -----
`default_nettype none

interface wctnp_req_if;
   import wctnp_pkg::*;

   logic       valid;
   logic       ready;
   func_type   func;
   weight_type weight;

   modport source (output valid, output func, output weight, input ready);
   modport sink (input valid, input func, input weight, output ready);
endinterface

interface wctnp_rsp_if;
   import wctnp_pkg::*;

   logic         valid;
   logic         ready;
   out_byte_type out_byte;
   logic         last;
   status_type   status;

   modport source (output valid, output out_byte, output last, output status, input ready);
   modport sink (input valid, input out_byte, input last, input status, output ready);
endinterface

interface wctnp_csr_if;
   import wctnp_pkg::*;

   logic          valid;
   logic          ready;
   csr_index_type index;
   csr_data_type  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/weight_corner_turn_nibble_pack_core.sv -----
// corner turn buffer for 3x3 conv weights, channel-major in, tap-major out
//
// req_chan: func load writes one weight, func drain asks for the next byte.
//   loads arrive output channel outer, tap inner; each lands at tap*Q+lane
//   in a single-write, dual-read store of BUF_ELEMS bytes
// rsp_chan: one beat per drain (byte, last flag, status); loads give none
// csr_chan: lane_groups, chan_block, nibble_mode; always ready. after a write
//   the block size is recomputed and req_ready is low for one cycle
// throughput: a load beat every cycle while req_ready is high; a drain passes
//   the store's registered read and then the byte assembly stage, and no
//   request beat is taken while it is in the read stage. a drain response is
//   registered through the read stage and then the output register
// a load followed at once by a drain needs no bypass: the write lands at the
//   accepting edge, the read happens at the next one
// reset: counters, flags, config and valid bits go to their reset values, not
//   the payload registers; no sweep of the store (contents undefined until loaded)
// stall: a pending response holds in the output register; req_ready drops
//   while it is not taken and while a drain is still in the store read
`default_nettype none

module weight_corner_turn_nibble_pack_core #(
   parameter int unsigned BUF_ELEMS = 4096,
   parameter int unsigned LANES     = 8
) (
   input wire logic clock,
   input wire logic reset,
   wctnp_req_if.sink   req_chan,
   wctnp_rsp_if.source rsp_chan,
   wctnp_csr_if.sink   csr_chan
);
   import wctnp_pkg::*;

   // widths
   localparam int unsigned QW = $clog2(255 * LANES + 1);   // output channels
   localparam int unsigned TW = QW + TAP_W;                // products
   localparam int unsigned AW = $clog2(BUF_ELEMS);         // store address
   localparam int unsigned EW = $clog2(BUF_ELEMS + 1);     // element count

   // config
   logic [QW-1:0]    q_ff, q_in;
   logic [TAP_W-1:0] k_ff, k_in;
   logic             nibble_ff, nibble_in;
   logic             dirty_ff, dirty_in;
   logic [EW-1:0]    elems_ff, elems_in;

   // load side
   logic [QW-1:0]    load_lane_ff, load_lane_in;
   logic [TAP_W-1:0] load_tap_ff, load_tap_in;
   logic             load_done_ff, load_done_in;
   logic             overflow_ff, overflow_in;

   // drain side
   logic [AW-1:0]    drain_idx_ff, drain_idx_in;

   // store read stage
   logic             p1_valid_ff, p1_valid_in;
   logic             p1_lo_ok_ff, p1_lo_ok_in;
   logic             p1_hi_ok_ff, p1_hi_ok_in;
   logic             p1_nibble_ff, p1_nibble_in;
   logic             p1_last_ff, p1_last_in;
   status_type       p1_status_ff, p1_status_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   out_byte_type     rsp_byte_ff, rsp_byte_in;
   logic             rsp_last_ff, rsp_last_in;
   status_type       rsp_status_ff, rsp_status_in;

   logic             req_fire;
   logic             load_fire;
   logic             drain_fire;
   logic             csr_fire;

   logic             load_ok;
   logic [TW-1:0]    load_addr;
   logic             load_in_buf;
   logic [TW-1:0]    total;

   logic [AW:0]      elem_lo;
   logic [AW:0]      elem_hi;
   logic [EW-1:0]    nbytes;
   logic             drain_last;

   logic             wr_en;
   weight_type       rd_lo;
   weight_type       rd_hi;
   logic [NIBBLE_W-1:0] nib_lo;
   logic [NIBBLE_W-1:0] nib_hi;

   // handshakes
   assign req_chan.ready = !dirty_ff && !p1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign load_fire      = req_fire && (req_chan.func == FUNC_LOAD);
   assign drain_fire     = req_fire && (req_chan.func == FUNC_DRAIN);
   assign csr_chan.ready = 1'b1;
   assign csr_fire       = csr_chan.valid;

   // block size, recomputed in the cycle after a register write
   assign total = TW'(q_ff) * TW'(k_ff);

   always_comb begin
      q_in      = q_ff;
      k_in      = k_ff;
      nibble_in = nibble_ff;
      dirty_in  = 1'b0;
      elems_in  = elems_ff;
      if (dirty_ff) begin
         if (total < TW'(BUF_ELEMS)) begin
            elems_in = EW'(total);
         end else begin
            elems_in = EW'(BUF_ELEMS);
         end
      end
      if (csr_fire) begin
         dirty_in = 1'b1;
         case (csr_chan.index)
            CSR_LANE_GROUPS: q_in      = QW'(csr_chan.data) * QW'(LANES);
            CSR_CHAN_BLOCK:  k_in      = TAP_W'(csr_chan.data) * TAP_W'(TAPS_PER_CHAN);
            CSR_NIBBLE_MODE: nibble_in = csr_chan.data[0];
            default:         dirty_in  = 1'b1;
         endcase
      end
   end

   // load address: tap * Q + lane
   assign load_ok     = !load_done_ff && (load_lane_ff < q_ff) && (load_tap_ff < k_ff);
   assign load_addr   = TW'(load_tap_ff) * TW'(q_ff) + TW'(load_lane_ff);
   assign load_in_buf = load_addr < TW'(BUF_ELEMS);
   assign wr_en       = load_fire && load_ok && load_in_buf;

   // drain element indexes and end of block
   assign elem_lo    = nibble_ff ? {drain_idx_ff, 1'b0} : {1'b0, drain_idx_ff};
   assign elem_hi    = elem_lo + (AW+1)'(1);
   assign nbytes     = nibble_ff ? EW'(({1'b0, elems_ff} + (EW+1)'(1)) >> 1) : elems_ff;
   assign drain_last = ((EW+1)'(drain_idx_ff) + (EW+1)'(1)) >= (EW+1)'(nbytes);

   // counters and flags
   always_comb begin
      load_lane_in = load_lane_ff;
      load_tap_in  = load_tap_ff;
      load_done_in = load_done_ff;
      overflow_in  = overflow_ff;
      drain_idx_in = drain_idx_ff;
      if (load_fire) begin
         if (!load_ok) begin
            overflow_in = 1'b1;
         end else begin
            if (!load_in_buf) begin
               overflow_in = 1'b1;
            end
            // counters advance even when the address falls outside the store
            if ((load_tap_ff + TAP_W'(1)) >= k_ff) begin
               load_tap_in = '0;
               if ((load_lane_ff + QW'(1)) >= q_ff) begin
                  load_lane_in = '0;
                  load_done_in = 1'b1;
               end else begin
                  load_lane_in = load_lane_ff + QW'(1);
               end
            end else begin
               load_tap_in = load_tap_ff + TAP_W'(1);
            end
         end
      end
      if (drain_fire) begin
         if (drain_last) begin
            // rearm for the next block
            drain_idx_in = '0;
            load_lane_in = '0;
            load_tap_in  = '0;
            load_done_in = 1'b0;
            overflow_in  = 1'b0;
         end else begin
            drain_idx_in = drain_idx_ff + AW'(1);
         end
      end
   end

   // read stage: flags travel with the store read
   always_comb begin
      p1_valid_in  = drain_fire;
      p1_lo_ok_in  = p1_lo_ok_ff;
      p1_hi_ok_in  = p1_hi_ok_ff;
      p1_nibble_in = p1_nibble_ff;
      p1_last_in   = p1_last_ff;
      p1_status_in = p1_status_ff;
      if (drain_fire) begin
         // elements past the block read as zero
         p1_lo_ok_in  = elem_lo < (AW+1)'(elems_ff);
         p1_hi_ok_in  = elem_hi < (AW+1)'(elems_ff);
         p1_nibble_in = nibble_ff;
         p1_last_in   = drain_last;
         if (overflow_ff) begin
            p1_status_in = STATUS_OVERFLOW;
         end else if (load_done_ff) begin
            p1_status_in = STATUS_OK;
         end else begin
            p1_status_in = STATUS_PARTIAL;
         end
      end
   end

   // byte assembly into the output register
   assign nib_lo = p1_lo_ok_ff ? (rd_lo[NIBBLE_W-1:0] & NIBBLE_MASK) : '0;
   assign nib_hi = p1_hi_ok_ff ? (rd_hi[NIBBLE_W-1:0] & NIBBLE_MASK) : '0;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      if (p1_valid_ff) begin
         rsp_valid_in  = 1'b1;
         rsp_last_in   = p1_last_ff;
         rsp_status_in = p1_status_ff;
         if (p1_nibble_ff) begin
            rsp_byte_in = {nib_hi, nib_lo};
         end else begin
            rsp_byte_in = p1_lo_ok_ff ? rd_lo : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff         <= QW'(LANES);
         k_ff         <= TAP_W'(TAPS_PER_CHAN);
         nibble_ff    <= 1'b0;
         dirty_ff     <= 1'b1;
         load_lane_ff <= '0;
         load_tap_ff  <= '0;
         load_done_ff <= 1'b0;
         overflow_ff  <= 1'b0;
         drain_idx_ff <= '0;
         p1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         q_ff         <= q_in;
         k_ff         <= k_in;
         nibble_ff    <= nibble_in;
         dirty_ff     <= dirty_in;
         load_lane_ff <= load_lane_in;
         load_tap_ff  <= load_tap_in;
         load_done_ff <= load_done_in;
         overflow_ff  <= overflow_in;
         drain_idx_ff <= drain_idx_in;
         p1_valid_ff  <= p1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      elems_ff      <= elems_in;
      p1_lo_ok_ff   <= p1_lo_ok_in;
      p1_hi_ok_ff   <= p1_hi_ok_in;
      p1_nibble_ff  <= p1_nibble_in;
      p1_last_ff    <= p1_last_in;
      p1_status_ff  <= p1_status_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   wctnp_store #(
      .DEPTH (BUF_ELEMS),
      .AW    (AW)
   ) u_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (load_addr[AW-1:0]),
      .wr_data    (req_chan.weight),
      .rd_en      (drain_fire),
      .rd_addr_lo (elem_lo[AW-1:0]),
      .rd_addr_hi (elem_hi[AW-1:0]),
      .rd_data_lo (rd_lo),
      .rd_data_hi (rd_hi)
   );

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.out_byte = rsp_byte_ff;
   assign rsp_chan.last     = rsp_last_ff;
   assign rsp_chan.status   = rsp_status_ff;

   // a completed block leaves the load counters at zero
   a_done_rearmed: assert property (@(posedge clock) disable iff (reset)
      load_done_ff |-> (load_lane_ff == '0) && (load_tap_ff == '0))
      else $error("load counters not at zero with block complete");

   // a drain beat always reaches the output register through the read stage
   a_drain_to_rsp: assert property (@(posedge clock) disable iff (reset)
      drain_fire |=> ##1 rsp_valid_ff)
      else $error("drain beat did not produce a response");

   // no request beat while the block size is being recomputed
   a_dirty_blocks: assert property (@(posedge clock) disable iff (reset)
      dirty_ff |-> !req_chan.ready)
      else $error("request taken with stale block size");

   // the read stage never overwrites a waiting response
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      p1_valid_ff |-> !rsp_valid_ff || $past(rsp_chan.ready) || !$past(rsp_valid_ff))
      else $error("response register overrun");

endmodule

`default_nettype wire

// ----- sv/wctnp_store.sv -----
`default_nettype none

module wctnp_store #(
   parameter int unsigned DEPTH = 4096,
   parameter int unsigned AW    = 12
) (
   input  wire logic                   clock,
   input  wire logic                   wr_en,
   input  wire logic [AW-1:0]          wr_addr,
   input  wire wctnp_pkg::weight_type  wr_data,
   input  wire logic                   rd_en,
   input  wire logic [AW-1:0]          rd_addr_lo,
   input  wire logic [AW-1:0]          rd_addr_hi,
   output      wctnp_pkg::weight_type  rd_data_lo,
   output      wctnp_pkg::weight_type  rd_data_hi
);
   import wctnp_pkg::*;

   weight_type store_mem [DEPTH];
   weight_type rd_lo_ff;
   weight_type rd_hi_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_lo_ff <= store_mem[rd_addr_lo];
         rd_hi_ff <= store_mem[rd_addr_hi];
      end
   end

   assign rd_data_lo = rd_lo_ff;
   assign rd_data_hi = rd_hi_ff;

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import wctnp_pkg::*;

   // block geometry, kept equal to the dut parameters
   localparam int unsigned STORE_DEPTH  = 4096;
   localparam int unsigned LANE_COUNT   = 8;
   // request beats over the whole run
   localparam int unsigned ITEM_COUNT   = 1250;
   // hang guard, far above the slowest legal run
   localparam int unsigned CYCLE_LIMIT  = 1000000;

   // one response beat: byte, last flag, status
   typedef struct packed {
      out_byte_type value;
      logic         last;
      status_type   status;
   } drain_beat_type;

   // one row of the opening directed sequence
   typedef struct packed {
      func_type       func;
      weight_type     weight;
      logic           typed;
      drain_beat_type beat;
   } stim_row_type;

   // default geometry: 8 lanes x 9 taps, byte mode
   // lane 0 taps 0..8 land at 0,8,..,64 and lane 1 at 1,9,..,65
   // then two early drains read entries 0 and 1 with the block a quarter loaded
   localparam stim_row_type DIRECTED_ROWS [20] = '{
      '{FUNC_LOAD,  8'h00, 1'b0, '0},
      '{FUNC_LOAD,  8'hFF, 1'b0, '0},
      '{FUNC_LOAD,  8'h0F, 1'b0, '0},
      '{FUNC_LOAD,  8'hF0, 1'b0, '0},
      '{FUNC_LOAD,  8'h55, 1'b0, '0},
      '{FUNC_LOAD,  8'hAA, 1'b0, '0},
      '{FUNC_LOAD,  8'h01, 1'b0, '0},
      '{FUNC_LOAD,  8'h80, 1'b0, '0},
      '{FUNC_LOAD,  8'h7F, 1'b0, '0},
      '{FUNC_LOAD,  8'hC3, 1'b0, '0},
      '{FUNC_LOAD,  8'h3C, 1'b0, '0},
      '{FUNC_LOAD,  8'h12, 1'b0, '0},
      '{FUNC_LOAD,  8'h34, 1'b0, '0},
      '{FUNC_LOAD,  8'h56, 1'b0, '0},
      '{FUNC_LOAD,  8'h78, 1'b0, '0},
      '{FUNC_LOAD,  8'h9A, 1'b0, '0},
      '{FUNC_LOAD,  8'hBC, 1'b0, '0},
      '{FUNC_LOAD,  8'hDE, 1'b0, '0},
      // drain before the block is complete: partial status, weight field ignored
      '{FUNC_DRAIN, 8'hFF, 1'b1, '{8'h00, 1'b0, STATUS_PARTIAL}},
      '{FUNC_DRAIN, 8'h00, 1'b1, '{8'hC3, 1'b0, STATUS_PARTIAL}}
   };

   logic clock = 1'b0;
   logic reset;

   wctnp_req_if req_bus ();
   wctnp_rsp_if rsp_bus ();
   wctnp_csr_if csr_bus ();

   weight_corner_turn_nibble_pack_core #(
      .BUF_ELEMS (STORE_DEPTH),
      .LANES     (LANE_COUNT)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // shadow of the corner turn buffer
   // ---------------------------------------------------------------

   // register copies, updated as csr beats are accepted
   logic [7:0]  cfg_lane_groups = 8'd1;
   logic [7:0]  cfg_chan_block  = 8'd1;
   logic        cfg_nibble      = 1'b0;

   weight_type  weight_store [STORE_DEPTH];
   // entries loaded at least once; drains never touch the others
   bit          entry_loaded [STORE_DEPTH];
   logic [10:0] load_lane     = '0;
   logic [11:0] load_tap      = '0;
   logic        load_done     = 1'b0;
   logic [12:0] drain_idx     = '0;
   logic        overflow_seen = 1'b0;
   // set when a drain closes the block and the counters rearm
   bit          block_closed  = 1'b0;

   drain_beat_type expected_bytes [$];
   drain_beat_type oldest;
   int unsigned fail_count   = 0;
   int unsigned items_sent   = 0;
   int unsigned detour_count = 0;
   int unsigned burst_left   = 0;
   int unsigned cycle_count  = 0;

   function automatic int unsigned block_lanes();
      return LANE_COUNT * cfg_lane_groups;
   endfunction

   function automatic int unsigned block_taps();
      return TAPS_PER_CHAN * cfg_chan_block;
   endfunction

   // elements in the block, capped by the store
   function automatic int unsigned block_elems();
      int unsigned total;
      total = block_lanes() * block_taps();
      return (total < STORE_DEPTH) ? total : STORE_DEPTH;
   endfunction

   // past the block end the element reads as zero
   function automatic weight_type store_elem(input int unsigned idx, input int unsigned elems);
      if (idx >= elems || idx >= STORE_DEPTH) return '0;
      return weight_store[idx];
   endfunction

   // true when the next drain only reads loaded entries
   function automatic bit drain_reads_loaded();
      int unsigned elems, e;
      elems = block_elems();
      e = cfg_nibble ? 2 * drain_idx : drain_idx;
      return (e >= elems || entry_loaded[e])
         && (!cfg_nibble || e + 1 >= elems || entry_loaded[e + 1]);
   endfunction

   // advance the shadow by one request beat; returns 1 with the byte a drain yields
   function automatic bit predict_corner_turn(input func_type f, input weight_type w,
                                              output drain_beat_type beat);
      int unsigned lanes, taps, elems, nbytes, addr, e;
      weight_type lo_w, hi_w;
      lanes = block_lanes();
      taps  = block_taps();
      elems = block_elems();
      beat  = '0;
      if (f == FUNC_LOAD) begin
         // block already full, or counters left outside a shrunken geometry
         if (load_done || load_lane >= lanes || load_tap >= taps) begin
            overflow_seen = 1'b1;
            return 1'b0;
         end
         // channel-major in, tap-major placement
         addr = load_tap * lanes + load_lane;
         if (addr < STORE_DEPTH) begin
            weight_store[addr] = w;
            entry_loaded[addr] = 1'b1;
         end else begin
            // beyond the store: dropped, counters still move
            overflow_seen = 1'b1;
         end
         if (load_tap + 1 >= taps) begin
            load_tap = '0;
            if (load_lane + 1 >= lanes) begin
               load_lane = '0;
               load_done = 1'b1;
            end else begin
               load_lane = load_lane + 1'b1;
            end
         end else begin
            load_tap = load_tap + 1'b1;
         end
         return 1'b0;
      end
      nbytes = cfg_nibble ? (elems + 1) / 2 : elems;
      if (cfg_nibble) begin
         // even element in the low nibble, odd one in the high nibble
         e = 2 * drain_idx;
         lo_w = store_elem(e, elems);
         hi_w = store_elem(e + 1, elems);
         beat.value = {hi_w[NIBBLE_W-1:0], lo_w[NIBBLE_W-1:0]};
      end else begin
         beat.value = store_elem(drain_idx, elems);
      end
      // at or past the end counts as the final byte
      beat.last = (drain_idx + 1 >= nbytes);
      beat.status = overflow_seen ? STATUS_OVERFLOW :
                    (load_done ? STATUS_OK : STATUS_PARTIAL);
      if (beat.last) begin
         drain_idx     = '0;
         load_lane     = '0;
         load_tap      = '0;
         load_done     = 1'b0;
         overflow_seen = 1'b0;
         block_closed  = 1'b1;
      end else begin
         drain_idx = drain_idx + 1'b1;
      end
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------
   // request side: bursts with random gaps, fields change at negedge
   // ---------------------------------------------------------------

   // send one beat; a typed row overrides the shadow's expected byte
   task automatic push_item(input func_type f, input weight_type w, input logic typed,
                            input drain_beat_type typed_beat);
      drain_beat_type beat;
      if (burst_left == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         // mostly short bursts, now and then a long gap-free stretch
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 24);
      end
      req_bus.valid  <= 1'b1;
      req_bus.func   <= f;
      req_bus.weight <= w;
      do @(posedge clock); while (!req_bus.ready);
      if (predict_corner_turn(f, w, beat))
         expected_bytes.push_back(typed ? typed_beat : beat);
      items_sent++;
      burst_left--;
      @(negedge clock);
   endtask

   // stop sending, let every byte come back, then allow for an in-flight load
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (expected_bytes.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // leaves csr valid high; the caller lowers it after its last write
   task automatic write_csr(input csr_index_type idx, input csr_data_type val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         CSR_LANE_GROUPS: cfg_lane_groups = val;
         CSR_CHAN_BLOCK:  cfg_chan_block  = val;
         CSR_NIBBLE_MODE: cfg_nibble      = val[0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // geometry changes only with the block quiet
   task automatic set_block_config(input csr_data_type lg, input csr_data_type cb,
                                   input logic nib);
      wait_idle();
      write_csr(CSR_LANE_GROUPS, lg);
      write_csr(CSR_CHAN_BLOCK, cb);
      write_csr(CSR_NIBBLE_MODE, csr_data_type'(nib));
      csr_bus.valid <= 1'b0;
   endtask

   // a few random beats under a wild geometry, then the block's own geometry back
   task automatic take_detour();
      logic [7:0]   keep_lg, keep_cb;
      logic         keep_nib;
      csr_data_type lg, cb;
      bit           drain;
      keep_lg  = cfg_lane_groups;
      keep_cb  = cfg_chan_block;
      keep_nib = cfg_nibble;
      if (detour_count == 0) begin
         // both sizes at their maximum
         lg = 8'd255;
         cb = 8'd255;
      end else begin
         lg = ($urandom_range(0, 2) == 0) ? 8'd255 : csr_data_type'($urandom_range(1, 255));
         cb = ($urandom_range(0, 2) == 0) ? 8'd255 : csr_data_type'($urandom_range(1, 255));
      end
      detour_count++;
      set_block_config(lg, cb, $urandom_range(0, 1) == 1);
      repeat ($urandom_range(8, 24)) begin
         drain = ($urandom_range(0, 1) == 1) && drain_reads_loaded();
         push_item(drain ? FUNC_DRAIN : FUNC_LOAD, weight_type'($urandom_range(0, 255)),
                   1'b0, '0);
      end
      set_block_config(keep_lg, keep_cb, keep_nib);
   endtask

   // well-formed block: loads until full, then drains to the final byte,
   // salted with early drains, stray loads and the odd full pause
   task automatic run_block(input bit with_detour);
      int unsigned detour_at, steps;
      bit loading, drain;
      block_closed = 1'b0;
      detour_at = $urandom_range(0, 100);
      steps = 0;
      while (!block_closed) begin
         loading = !load_done && load_lane < block_lanes() && load_tap < block_taps();
         if (with_detour && steps == detour_at) begin
            take_detour();
         end else if (!loading && !drain_reads_loaded()) begin
            // counters stranded past entries never loaded: the default-size
            // block is fully loaded, so its geometry drains to the end
            set_block_config(8'd1, 8'd1, cfg_nibble);
         end else begin
            if (loading)
               drain = ($urandom_range(0, 99) < 4) && drain_reads_loaded();
            else
               drain = ($urandom_range(0, 99) >= 6);
            if ($urandom_range(0, 199) == 0)
               wait_idle();
            push_item(drain ? FUNC_DRAIN : FUNC_LOAD, weight_type'($urandom_range(0, 255)),
                      1'b0, '0);
         end
         steps++;
      end
   endtask

   // ---------------------------------------------------------------
   // response side: stall pattern of its own
   // ---------------------------------------------------------------

   initial begin
      int unsigned stall_mode, stall_left;
      logic [31:0] stall_word;
      rsp_bus.ready = 1'b0;
      stall_mode = 0;
      stall_left = 0;
      stall_word = '0;
      forever begin
         @(negedge clock);
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 96);
            stall_word = $urandom;
         end
         stall_left--;
         case (stall_mode)
            0: rsp_bus.ready <= 1'b1;                          // no stalls at all
            1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);   // light stalling
            2: rsp_bus.ready <= stall_word[stall_left % 32];   // fixed bit pattern
            default: rsp_bus.ready <= ($urandom_range(0, 1) == 1);
         endcase
      end
   end

   // compare every accepted response beat with the oldest expected byte
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_bytes.size() == 0) begin
            $error("response beat with nothing expected: out_byte 0x%02h last %0d status %0d",
                   rsp_bus.out_byte, rsp_bus.last, rsp_bus.status);
            fail_count++;
         end else begin
            oldest = expected_bytes.pop_front();
            if (rsp_bus.out_byte !== oldest.value) begin
               $error("out_byte: expected 0x%02h, got 0x%02h", oldest.value, rsp_bus.out_byte);
               fail_count++;
            end
            if (rsp_bus.last !== oldest.last) begin
               $error("last: expected %0d, got %0d", oldest.last, rsp_bus.last);
               fail_count++;
            end
            if (rsp_bus.status !== oldest.status) begin
               $error("status: expected %0d, got %0d", oldest.status, rsp_bus.status);
               fail_count++;
            end
         end
      end
   end

   // hang guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $error("timeout after %0d cycles, %0d bytes outstanding",
                cycle_count, expected_bytes.size());
         $display("weight_corner_turn_nibble_pack_core: mismatch");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // run sequence
   // ---------------------------------------------------------------

   initial begin
      csr_data_type lg, cb;
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.func   = FUNC_LOAD;
      req_bus.weight = '0;
      csr_bus.valid  = 1'b0;
      csr_bus.index  = CSR_LANE_GROUPS;
      csr_bus.data   = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows under the reset geometry
      foreach (DIRECTED_ROWS[i])
         push_item(DIRECTED_ROWS[i].func, DIRECTED_ROWS[i].weight, DIRECTED_ROWS[i].typed,
                   DIRECTED_ROWS[i].beat);

      // finish the quarter-loaded default block from where the rows left it
      run_block(1'b0);

      // random blocks, mostly small, about half with a geometry detour; the
      // first detour pushes both sizes to their maximum, so loads can run past the store
      while (items_sent < ITEM_COUNT) begin
         lg = ($urandom_range(0, 4) == 0) ? 8'd3 : csr_data_type'($urandom_range(1, 2));
         cb = ($urandom_range(0, 4) == 0) ? 8'd2 : 8'd1;
         set_block_config(lg, cb, $urandom_range(0, 1) == 1);
         run_block($urandom_range(0, 1) == 1);
      end

      // drain out, then a few quiet cycles for anything late
      wait_idle();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("weight_corner_turn_nibble_pack_core: match");
      else
         $display("weight_corner_turn_nibble_pack_core: mismatch");
      $finish;
   end

endmodule

// ----- weight_corner_turn_nibble_pack_core.f -----
sv/wctnp_pkg.sv
sv/wctnp_if.sv
sv/wctnp_store.sv
sv/weight_corner_turn_nibble_pack_core.sv
bench/testbench.sv
